@@ rtl/rgbhsl_pkg.sv @@
// Shared constants for the RGB to HSL converter.
// Default widths and the stage count ahead of the dividers.
// No dependencies.
package rgbhsl_pkg;

  localparam int CHANNEL_BITS_DEF  = 8;
  localparam int FRACTION_BITS_DEF = 16;

  // Stages ahead of the dividers: min/max select, then operand build.
  localparam int DIV_LEAD_STAGES = 2;

endpackage

@@ rtl/rgb_to_hsl_converter_core.sv @@
// RGB to HSL converter, top level: min/max and operand stages, then pipelined
// dividers for hue and saturation and a shift-and-add reciprocal path for lightness.
// Depends on rgbhsl_pkg and rgbhsl_div.
//
//   channel  valid      stall      payload
//   pixel    pix_valid  pix_stall  red, green, blue
//   result   hsl_valid  hsl_stall  hue, saturation, lightness
//
// One pixel enters per cycle while pix_stall is low; an accepted beat is offered on the
// result side after it has passed through FRACTION_BITS + 3 register stages.
// Those are the two operand stages plus one divider stage per quotient bit.
// Reset clears only the stage valid bits.
// A stalled result freezes the pipeline, but the first stage still takes a beat
// when it is empty.
module rgb_to_hsl_converter_core #(
  parameter int CHANNEL_BITS  = rgbhsl_pkg::CHANNEL_BITS_DEF,
  parameter int FRACTION_BITS = rgbhsl_pkg::FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pix_valid,
  output logic                     pix_stall,
  input  logic [CHANNEL_BITS-1:0]  red,
  input  logic [CHANNEL_BITS-1:0]  green,
  input  logic [CHANNEL_BITS-1:0]  blue,
  output logic                     hsl_valid,
  input  logic                     hsl_stall,
  output logic [FRACTION_BITS-1:0] hue,
  output logic [FRACTION_BITS:0]   saturation,
  output logic [FRACTION_BITS:0]   lightness
);
  import rgbhsl_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int QB = FRACTION_BITS + 1;
  localparam int NS = DIV_LEAD_STAGES + QB;

  localparam int LN  = (FRACTION_BITS + CB - 1) / CB;
  localparam int LSH = LN * CB;
  localparam int LPW = CB + FRACTION_BITS + LSH + 1;

  localparam logic [1:0] SEC_RED_POS = 2'd0;
  localparam logic [1:0] SEC_RED_NEG = 2'd1;
  localparam logic [1:0] SEC_GREEN   = 2'd2;
  localparam logic [1:0] SEC_BLUE    = 2'd3;

  localparam logic [CB:0] FULL2 = {{CB{1'b1}}, 1'b0};

  logic [NS-1:0] vld;
  logic          adv;
  logic          en0;

  logic [CB-1:0] hi_next, lo_next;
  logic [1:0]    sec_next;
  logic [CB:0]   diff_next;
  logic          rmax, gmax;

  logic [CB-1:0] a_hi, a_lo;
  logic [1:0]    a_sec;
  logic [CB:0]   a_diff;

  logic [CB-1:0] d;
  logic [CB:0]   sum;
  logic [CB+2:0] d6;
  logic [CB+2:0] kd;
  logic [CB+2:0] hnum;
  logic [CB-1:0] sden_next;
  logic [CB+2:0] hden_next;

  logic [CB:0]   b_lnum;
  logic [CB-1:0] b_snum;
  logic [CB-1:0] b_sden;
  logic [CB+2:0] b_hnum;
  logic [CB+2:0] b_hden;

  logic [LPW-1:0] lterm;
  logic [LPW-1:0] lprod_next;
  logic [LPW-1:0] l_prod;
  logic [LPW-1:0] lround;
  logic [QB-1:0]  lquo_next;
  logic [QB-1:0]  light_pipe [QB-1];

  logic [QB-1:0] sat_quo;
  logic [QB-1:0] hue_quo;

  assign adv       = !(vld[NS-1] && hsl_stall);
  assign en0       = adv || !vld[0];
  assign pix_stall = !en0;
  assign hsl_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en0) begin
        vld[0] <= pix_valid;
      end
      if (adv) begin
        vld[NS-1:1] <= vld[NS-2:0];
      end
    end
  end

  always_comb begin
    rmax    = (red >= green) && (red >= blue);
    gmax    = !rmax && (green >= blue);
    hi_next = rmax ? red : (gmax ? green : blue);
    if ((red <= green) && (red <= blue)) begin
      lo_next = red;
    end else if (green <= blue) begin
      lo_next = green;
    end else begin
      lo_next = blue;
    end
    if (rmax) begin
      sec_next  = (green < blue) ? SEC_RED_NEG : SEC_RED_POS;
      diff_next = {1'b0, green} - {1'b0, blue};
    end else if (gmax) begin
      sec_next  = SEC_GREEN;
      diff_next = {1'b0, blue} - {1'b0, red};
    end else begin
      sec_next  = SEC_BLUE;
      diff_next = {1'b0, red} - {1'b0, green};
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      a_hi   <= hi_next;
      a_lo   <= lo_next;
      a_sec  <= sec_next;
      a_diff <= diff_next;
    end
  end

  always_comb begin
    d   = a_hi - a_lo;
    sum = {1'b0, a_hi} + {1'b0, a_lo};
    d6  = (CB+3)'({d, 2'b00}) + (CB+3)'({d, 1'b0});
    case (a_sec)
      SEC_RED_POS: kd = '0;
      SEC_RED_NEG: kd = d6;
      SEC_GREEN:   kd = (CB+3)'({d, 1'b0});
      SEC_BLUE:    kd = (CB+3)'({d, 2'b00});
      default:     kd = '0;
    endcase
    hnum = kd + {{2{a_diff[CB]}}, a_diff};
    if (d == '0) begin
      sden_next = CB'(1);
      hden_next = (CB+3)'(1);
    end else begin
      sden_next = sum[CB] ? CB'(FULL2 - sum) : sum[CB-1:0];
      hden_next = d6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_lnum <= sum;
      b_snum <= d;
      b_sden <= sden_next;
      b_hnum <= (d == '0) ? '0 : hnum;
      b_hden <= hden_next;
    end
  end

  // Lightness is floor(2^(FRACTION_BITS-1) * sum / F) with F = 2^CB - 1. Scaling by
  // (2^LSH - 1) / F turns the divisor into 2^LSH - 1, which a shift and add resolves.
  always_comb begin
    lterm      = LPW'(b_lnum) << (FRACTION_BITS - 1);
    lprod_next = '0;
    for (int k = 0; k < LN; k++) begin
      lprod_next = lprod_next + (lterm << (k * CB));
    end
    lround    = l_prod + (l_prod >> LSH) + LPW'(1);
    lquo_next = QB'(lround >> LSH);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_prod        <= lprod_next;
      light_pipe[0] <= lquo_next;
      for (int k = 1; k < QB - 1; k++) begin
        light_pipe[k] <= light_pipe[k-1];
      end
    end
  end

  rgbhsl_div #(
    .NUM_BITS (CB),
    .DEN_BITS (CB),
    .SHIFT    (FRACTION_BITS),
    .QUO_BITS (QB)
  ) u_sat_div (
    .clk (clk),
    .en  (adv),
    .num (b_snum),
    .den (b_sden),
    .quo (sat_quo)
  );

  rgbhsl_div #(
    .NUM_BITS (CB + 3),
    .DEN_BITS (CB + 3),
    .SHIFT    (FRACTION_BITS),
    .QUO_BITS (QB)
  ) u_hue_div (
    .clk (clk),
    .en  (adv),
    .num (b_hnum),
    .den (b_hden),
    .quo (hue_quo)
  );

  assign hue        = hue_quo[FRACTION_BITS-1:0];
  assign saturation = sat_quo;
  assign lightness  = light_pipe[QB-2];

endmodule

@@ rtl/rgbhsl_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Computes floor((num << SHIFT) / den). The quotient must fit in QUO_BITS.
// Depends on nothing. All stages advance together on en.
module rgbhsl_div #(
  parameter int NUM_BITS = 9,
  parameter int DEN_BITS = 9,
  parameter int SHIFT    = 16,
  parameter int QUO_BITS = 17
) (
  input  logic                clk,
  input  logic                en,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic [QUO_BITS-1:0] quo
);

  localparam int XW = NUM_BITS + SHIFT;

  logic [XW-1:0]       dividend;
  logic [DEN_BITS-1:0] rem_in  [QUO_BITS];
  logic [DEN_BITS-1:0] rem     [QUO_BITS];
  logic [DEN_BITS-1:0] den_in  [QUO_BITS];
  logic [DEN_BITS-1:0] den_q   [QUO_BITS];
  logic [QUO_BITS-1:0] low_in  [QUO_BITS];
  logic [QUO_BITS-1:0] low     [QUO_BITS];
  logic [QUO_BITS-1:0] quo_in  [QUO_BITS];
  logic [QUO_BITS-1:0] quo_q   [QUO_BITS];

  assign dividend  = {num, {SHIFT{1'b0}}};
  assign rem_in[0] = DEN_BITS'(dividend >> QUO_BITS);
  assign low_in[0] = dividend[QUO_BITS-1:0];
  assign den_in[0] = den;
  assign quo_in[0] = '0;

  for (genvar j = 1; j < QUO_BITS; j++) begin : g_link
    assign rem_in[j] = rem[j-1];
    assign low_in[j] = low[j-1];
    assign den_in[j] = den_q[j-1];
    assign quo_in[j] = quo_q[j-1];
  end

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
    logic [DEN_BITS:0] trial;
    logic [DEN_BITS:0] diff;
    logic              ge;

    always_comb begin
      trial = {rem_in[j], low_in[j][QUO_BITS-1]};
      diff  = trial - {1'b0, den_in[j]};
      ge    = (trial >= {1'b0, den_in[j]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]   <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        low[j]   <= {low_in[j][QUO_BITS-2:0], 1'b0};
        den_q[j] <= den_in[j];
        quo_q[j] <= {quo_in[j][QUO_BITS-2:0], ge};
      end
    end
  end

  assign quo = quo_q[QUO_BITS-1];

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for rgb_to_hsl_converter_core: directed and random pixels,
// with bursty input and a stalling result side. Uses rgbhsl_pkg for the default widths.
module testbench;

  localparam int CB = rgbhsl_pkg::CHANNEL_BITS_DEF;
  localparam int FB = rgbhsl_pkg::FRACTION_BITS_DEF;
  localparam int LATENCY = FB + 3;
  localparam int RANDOM_PIXELS = 1930;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTS = 30;

  typedef struct packed {
    logic [FB-1:0] hue;
    logic [FB:0]   saturation;
    logic [FB:0]   lightness;
  } hsl_t;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
    logic          has_want;
    hsl_t          want;
  } pix_row_t;

  localparam int DIRECTED_ROWS = 21;
  localparam pix_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{16'd0,     17'd0,     17'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{16'd0,     17'd0,     17'd65536}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{16'd0,     17'd65536, 17'd32768}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{16'd21845, 17'd65536, 17'd32768}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{16'd43690, 17'd65536, 17'd32768}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{16'd0,     17'd0,     17'd32896}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{16'd10922, 17'd65536, 17'd32768}},
    '{8'd1,   8'd0,   8'd0,   1'b1, '{16'd0,     17'd65536, 17'd128}},
    '{8'd0,   8'd255, 8'd255, 1'b0, '{16'd0, 17'd0, 17'd0}},
    '{8'd255, 8'd0,   8'd255, 1'b0, '{16'd0, 17'd0, 17'd0}},
    '{8'd255, 8'd0,   8'd1,   1'b0, '{16'd0, 17'd0, 17'd0}},
    '{8'd255, 8'd254, 8'd255, 1'b0, '{16'd0, 17'd0, 17'd0}},
    '{8'd200, 8'd100, 8'd55,  1'b0, '{16'd0, 17'd0, 17'd0}},
    '{8'd201, 8'd100, 8'd55,  1'b0, '{16'd0, 17'd0, 17'd0}},
    '{8'd255, 8'd128, 8'd200, 1'b0, '{16'd0, 17'd0, 17'd0}},
    '{8'd254, 8'd255, 8'd254, 1'b0, '{16'd0, 17'd0, 17'd0}},
    '{8'd0,   8'd128, 8'd255, 1'b0, '{16'd0, 17'd0, 17'd0}},
    '{8'd170, 8'd85,  8'd0,   1'b0, '{16'd0, 17'd0, 17'd0}},
    '{8'd85,  8'd170, 8'd255, 1'b0, '{16'd0, 17'd0, 17'd0}},
    '{8'd255, 8'd1,   8'd0,   1'b0, '{16'd0, 17'd0, 17'd0}},
    '{8'd1,   8'd255, 8'd254, 1'b0, '{16'd0, 17'd0, 17'd0}}
  };

  logic          clk;
  logic          rst;
  logic          pix_valid;
  logic          pix_stall;
  logic [CB-1:0] red;
  logic [CB-1:0] green;
  logic [CB-1:0] blue;
  logic          hsl_valid;
  logic          hsl_stall;
  logic [FB-1:0] hue;
  logic [FB:0]   saturation;
  logic [FB:0]   lightness;

  hsl_t        pending_hsl [$];
  int          mismatch_count = 0;
  int          pixels_sent = 0;
  int unsigned cycle_count = 0;

  rgb_to_hsl_converter_core #(
    .CHANNEL_BITS (CB),
    .FRACTION_BITS(FB)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .hsl_valid (hsl_valid),
    .hsl_stall (hsl_stall),
    .hue       (hue),
    .saturation(saturation),
    .lightness (lightness)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic hsl_t predict_hsl(input logic [CB-1:0] r, input logic [CB-1:0] g,
                                       input logic [CB-1:0] b);
    longint unsigned full, unit, hi, lo, sum, d, den, num;
    hsl_t res;
    full = (64'd1 << CB) - 1;
    unit = 64'd1 << FB;
    hi = 64'(r);
    lo = 64'(r);
    if (64'(g) > hi) hi = 64'(g);
    if (64'(b) > hi) hi = 64'(b);
    if (64'(g) < lo) lo = 64'(g);
    if (64'(b) < lo) lo = 64'(b);
    sum = hi + lo;
    d = hi - lo;
    res.lightness = (FB+1)'((unit * sum) / (2 * full));
    res.hue = '0;
    res.saturation = '0;
    if (d != 0) begin
      den = (sum <= full) ? sum : (2 * full - sum);
      res.saturation = (FB+1)'((unit * d) / den);
      if (hi == 64'(r)) num = (g < b) ? (6 * d - 64'(b - g)) : 64'(g - b);
      else if (hi == 64'(g)) num = 2 * d + 64'(b) - 64'(r);
      else num = 4 * d + 64'(r) - 64'(g);
      res.hue = FB'((unit * num) / (6 * d));
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic pick_pixel(output logic [CB-1:0] r, output logic [CB-1:0] g,
                            output logic [CB-1:0] b);
    logic [CB-1:0] ch [3];
    int kind, top, bot, pos;
    for (int i = 0; i < 3; i++) ch[i] = CB'($urandom);
    kind = $urandom_range(0, 9);
    pos = $urandom_range(0, 2);
    case (kind)
      4: begin
        ch[1] = ch[0];
        ch[2] = ch[0];
      end
      5: begin
        top = $urandom_range(1, 255);
        ch[pos] = CB'(top);
        ch[(pos + 1) % 3] = CB'(top);
        ch[(pos + 2) % 3] = CB'($urandom_range(0, top - 1));
      end
      6: begin
        ch[1] = ch[0] ^ CB'($urandom_range(0, 1));
        ch[2] = ch[0] ^ CB'($urandom_range(0, 1));
      end
      7: begin
        top = $urandom_range(128, 255);
        bot = 254 + int'($urandom_range(0, 2)) - top;
        if (bot < 0) bot = 0;
        if (bot > top) bot = top;
        ch[pos] = CB'(top);
        ch[(pos + 1) % 3] = CB'(bot);
        ch[(pos + 2) % 3] = CB'($urandom_range(bot, top));
      end
      8: begin
        for (int i = 0; i < 3; i++) ch[i] = ($urandom_range(0, 1) != 0) ? '1 : '0;
      end
      9: begin
        for (int i = 0; i < 3; i++)
          if (i != pos) ch[i] = ($urandom_range(0, 1) != 0) ? '1 : '0;
      end
      default: ;
    endcase
    r = ch[0];
    g = ch[1];
    b = ch[2];
  endtask

  task automatic offer_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                             input logic [CB-1:0] b, input logic has_want, input hsl_t want);
    pix_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    pending_hsl.insert(pending_hsl.size(), has_want ? want : predict_hsl(r, g, b));
    pixels_sent++;
  endtask

  always @(posedge clk) begin : result_check
    hsl_t want;
    if (!rst && hsl_valid && !hsl_stall) begin
      if (pending_hsl.size() == 0) begin
        report_mismatch($sformatf("unexpected beat hue=%0d sat=%0d light=%0d",
                                  hue, saturation, lightness));
      end else begin
        want = pending_hsl.pop_front();
        if (hue !== want.hue)
          report_mismatch($sformatf("hue %0d, expected %0d", hue, want.hue));
        if (saturation !== want.saturation)
          report_mismatch($sformatf("saturation %0d, expected %0d", saturation,
                                    want.saturation));
        if (lightness !== want.lightness)
          report_mismatch($sformatf("lightness %0d, expected %0d", lightness,
                                    want.lightness));
      end
    end
  end

  initial begin : result_stall_gen
    int mode, span;
    bit held;
    held = 1'b0;
    hsl_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && pixels_sent >= 400) begin
        held = 1'b1;
        hsl_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      repeat (span) begin
        case (mode)
          0: hsl_stall <= 1'b0;
          1: hsl_stall <= ($urandom_range(0, 1) != 0);
          2: hsl_stall <= ((cycle_count % 5) == 2);
          default: hsl_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : pixel_source
    logic [CB-1:0] r, g, b;
    int burst_left;
    hsl_t none;
    none = '0;
    rst = 1'b1;
    pix_valid = 1'b0;
    red = '0;
    green = '0;
    blue = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 60);
    for (int n = 0; n < DIRECTED_ROWS + RANDOM_PIXELS; n++) begin
      if (n < DIRECTED_ROWS) begin
        offer_pixel(DIRECTED[n].red, DIRECTED[n].green, DIRECTED[n].blue,
                    DIRECTED[n].has_want, DIRECTED[n].want);
      end else begin
        pick_pixel(r, g, b);
        offer_pixel(r, g, b, 1'b0, none);
      end
      burst_left--;
      if (burst_left == 0) begin
        pix_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 60);
      end
    end
    pix_valid <= 1'b0;
    while (pending_hsl.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ rgb_to_hsl_converter_core.f @@
rtl/rgbhsl_pkg.sv
rtl/rgbhsl_div.sv
rtl/rgb_to_hsl_converter_core.sv
bench/testbench.sv
